>>> hdl/bpsm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bpsm_pkg;

  // Fixed field widths
  localparam int ADDR_W        = 48;
  localparam int HIT_W         = 9;
  localparam int LEN_W         = 5;
  localparam int CFG_W         = 64;
  localparam int PADDR_W       = 5;
  localparam int PATTERN_BYTES = 16;

  // Defaults for the top-level parameters
  localparam int DEF_MAX_PATTERN_BYTES = 16;
  localparam int DEF_MAX_HIT_COUNT     = 256;

  // Register map, one 64-bit register every 8 bytes
  typedef enum logic [1:0] {
    REG_PAT_LO  = 2'd0,
    REG_PAT_HI  = 2'd1,
    REG_PAT_LEN = 2'd2,
    REG_HIT_LIM = 2'd3
  } reg_index_t;

  // Per-cell control: shift strobe and whether the cell takes part in the compare
  typedef struct packed {
    logic shift;
    logic used;
  } cell_ctrl_t;

  // Pattern byte by position; positions past the sixteenth read as zero
  function automatic logic [7:0] pattern_byte(input logic [8*PATTERN_BYTES-1:0] pat,
                                              input int unsigned idx);
    logic [7:0] b;
    b = 8'd0;
    if (idx < PATTERN_BYTES) begin
      b = pat[{idx[3:0], 3'b000} +: 8];
    end
    return b;
  endfunction

endpackage

`default_nettype wire

>>> hdl/bpsm_cell.sv
`timescale 1ns / 1ps
`default_nettype none

// One window position: holds a byte, passes it on, and flags a compare hit
module bpsm_cell
  import bpsm_pkg::*;
(
  input  wire logic       clk,
  input  wire cell_ctrl_t ctrl,
  input  wire logic [7:0] byte_in,
  input  wire logic [7:0] pat_byte,
  output logic      [7:0] byte_out,
  output logic            eq
);

  logic [7:0] held;

  // Shift in the neighbour's byte and compare it with this cell's pattern byte
  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      held <= byte_in;
      eq   <= !ctrl.used || (byte_in == pat_byte);
    end
  end

  assign byte_out = held;

endmodule

`default_nettype wire

>>> hdl/byte_pattern_stream_matcher.sv
// A match is registered in the compare cells and stage 1, then its result in the output register.
// Throughput: one byte per cycle unless the output stalls; each byte shifts through a chain of compare cells in step.
// The output register lets a new byte in while a result waits to be taken.
// Reset (rst, synchronous): clears the hit count, segment fill and pipeline valids,
// and returns the registers to pattern zero, length 1, hit limit 256. No clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module byte_pattern_stream_matcher
  import bpsm_pkg::*;
#(
  parameter int MAX_PATTERN_BYTES = DEF_MAX_PATTERN_BYTES,
  parameter int MAX_HIT_COUNT     = DEF_MAX_HIT_COUNT
) (
  input  wire logic               clk,
  input  wire logic               rst,
  // configuration port
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [CFG_W-1:0]   pwdata,
  output logic      [CFG_W-1:0]   prdata,
  output logic                    pready,
  // input channel
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [7:0]         data_byte,
  input  wire logic [ADDR_W-1:0]  byte_address,
  input  wire logic               segment_first,
  // result channel
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic      [ADDR_W-1:0]  match_address,
  output logic      [HIT_W-1:0]   hit_number
);

  localparam int FILL_W = $clog2(MAX_PATTERN_BYTES + 1);

  logic [CFG_W-1:0] pat_lo;
  logic [CFG_W-1:0] pat_hi;
  logic [LEN_W-1:0] pat_len;
  logic [HIT_W-1:0] hit_lim;

  logic              cfg_wr;
  reg_index_t        cfg_idx;
  logic [FILL_W-1:0] len_eff;
  logic [HIT_W-1:0]  lim_eff;

  logic              accept;
  logic [FILL_W-1:0] fill;
  logic [FILL_W-1:0] fill_base;
  logic [FILL_W-1:0] fill_next;

  logic [7:0]                   win [MAX_PATTERN_BYTES];
  logic [MAX_PATTERN_BYTES-1:0] eq_vec;

  logic              s1_valid;
  logic              s1_len_ok;
  logic [ADDR_W-1:0] s1_addr;
  logic              s1_take;
  logic              emit;
  logic [HIT_W-1:0]  hits;

  // Register access
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = reg_index_t'(paddr[4:3]);

  always_ff @(posedge clk) begin
    if (rst) begin
      pat_lo  <= '0;
      pat_hi  <= '0;
      pat_len <= LEN_W'(1);
      hit_lim <= HIT_W'(256);
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_PAT_LO:  pat_lo  <= pwdata;
        REG_PAT_HI:  pat_hi  <= pwdata;
        REG_PAT_LEN: pat_len <= pwdata[LEN_W-1:0];
        REG_HIT_LIM: hit_lim <= pwdata[HIT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_PAT_LO:  prdata = pat_lo;
      REG_PAT_HI:  prdata = pat_hi;
      REG_PAT_LEN: prdata = CFG_W'(pat_len);
      REG_HIT_LIM: prdata = CFG_W'(hit_lim);
      default:     prdata = '0;
    endcase
  end

  // Clamp length to 1..MAX_PATTERN_BYTES and limit to MAX_HIT_COUNT
  always_comb begin
    if (pat_len == '0) begin
      len_eff = FILL_W'(1);
    end else if (32'(pat_len) > MAX_PATTERN_BYTES) begin
      len_eff = FILL_W'(MAX_PATTERN_BYTES);
    end else begin
      len_eff = FILL_W'(pat_len);
    end
    if (32'(hit_lim) > MAX_HIT_COUNT) begin
      lim_eff = HIT_W'(MAX_HIT_COUNT);
    end else begin
      lim_eff = hit_lim;
    end
  end

  // Handshake: stage 1 drains whenever the output register is free or being emptied
  assign s1_take  = !out_valid || out_ready;
  assign in_ready = !s1_valid || s1_take;
  assign accept   = in_valid && in_ready;

  // Segment fill, saturating at the window depth
  always_comb begin
    fill_base = segment_first ? '0 : fill;
    if (32'(fill_base) < MAX_PATTERN_BYTES) begin
      fill_next = fill_base + FILL_W'(1);
    end else begin
      fill_next = fill_base;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (accept) begin
      fill <= fill_next;
    end
  end

  // Window: cell k holds the byte k places back; it is checked against
  // pattern byte (len - 1 - k) when k lies inside the pattern
  for (genvar k = 0; k < MAX_PATTERN_BYTES; k++) begin : g_cell
    cell_ctrl_t ctrl;
    logic [7:0] pbyte;
    logic [7:0] bin;

    assign ctrl.shift = accept;
    assign ctrl.used  = 32'(len_eff) > k;
    assign pbyte      = pattern_byte({pat_hi, pat_lo}, 32'(len_eff) - 32'd1 - k);

    if (k == 0) begin : g_head
      assign bin = data_byte;
    end else begin : g_body
      assign bin = win[k-1];
    end

    bpsm_cell u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .byte_in  (bin),
      .pat_byte (pbyte),
      .byte_out (win[k]),
      .eq       (eq_vec[k])
    );
  end

  // Stage 1: compare flags sit in the cells, fill check and address here
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_len_ok <= fill_next >= len_eff;
      s1_addr   <= byte_address;
    end
  end

  // Hit limit check and output register
  assign emit = s1_valid && s1_take && s1_len_ok && (&eq_vec) && (hits < lim_eff);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      hits      <= '0;
    end else begin
      // a new result reloads the register, otherwise a transfer empties it
      if (emit) begin
        out_valid <= 1'b1;
        hits      <= hits + HIT_W'(1);
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      match_address <= s1_addr - ADDR_W'(len_eff - FILL_W'(1));
      hit_number    <= hits + HIT_W'(1);
    end
  end

endmodule

`default_nettype wire

>>> hdl/bpsm_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module bpsm_checker
  import bpsm_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              in_ready,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic [ADDR_W-1:0] match_address,
  input wire logic [HIT_W-1:0]  hit_number
);

  logic [HIT_W-1:0] last_hit;

  // Ordinal of the last result transferred
  always_ff @(posedge clk) begin
    if (rst) begin
      last_hit <= '0;
    end else if (out_valid && out_ready) begin
      last_hit <= hit_number;
    end
  end

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(match_address) && $stable(hit_number))
    else $error("result changed while stalled");

  // Results are numbered consecutively from 1
  a_hit_seq: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> hit_number == last_hit + HIT_W'(1))
    else $error("hit number out of sequence");

  // Reset empties the output
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result present after reset");

  // An empty output never blocks the input
  a_no_block: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

endmodule

bind byte_pattern_stream_matcher bpsm_checker u_bpsm_checker (
  .clk           (clk),
  .rst           (rst),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .match_address (match_address),
  .hit_number    (hit_number)
);

`default_nettype wire
